### hdl/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

    // Default list capacity, and the width of the count fields.
    localparam int MAX_TERMS_DEF = 32;
    localparam int CNT_W         = 6;

    // Field widths of the streams.
    localparam int COEF_W  = 16;
    localparam int EXP_W   = 16;
    localparam int RCOEF_W = 17;
    localparam int TCNT_W  = 7;
    localparam int TERM_W  = COEF_W + EXP_W;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_SUB    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Subtract request handed from the front end to the merge engine.
    typedef struct packed {
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_b;
        logic             dropped;
    } cmd_t;

endpackage

### hdl/sps_ram.sv
`timescale 1ns / 1ps

module sps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [WIDTH-1:0]      rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sps_front.sv
`timescale 1ns / 1ps

module sps_front #(
    parameter int MAX_TERMS = sps_pkg::MAX_TERMS_DEF,
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [1:0]                  operation,
    input  logic [sps_pkg::COEF_W-1:0]  coefficient,
    input  logic [sps_pkg::EXP_W-1:0]   exponent,
    output logic                        a_wr_en,
    output logic                        b_wr_en,
    output logic [AW-1:0]               a_wr_addr,
    output logic [AW-1:0]               b_wr_addr,
    output logic [sps_pkg::TERM_W-1:0]  wr_term,
    output logic                        cmd_push,
    output sps_pkg::cmd_t               cmd
);
    localparam logic [sps_pkg::CNT_W-1:0] CAP = sps_pkg::CNT_W'(MAX_TERMS);

    logic [sps_pkg::CNT_W-1:0] count_a_reg, count_a_next;
    logic [sps_pkg::CNT_W-1:0] count_b_reg, count_b_next;
    logic                      dropped_reg, dropped_next;
    sps_pkg::op_t              op;

    assign op        = sps_pkg::op_t'(operation);
    assign a_wr_addr = count_a_reg[AW-1:0];
    assign b_wr_addr = count_b_reg[AW-1:0];
    assign wr_term   = {exponent, coefficient};
    assign cmd       = '{count_a: count_a_reg, count_b: count_b_reg, dropped: dropped_reg};

    // Classify each accepted request: store a term, or hand off a subtract.
    always_comb begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        dropped_next = dropped_reg;
        a_wr_en      = 1'b0;
        b_wr_en      = 1'b0;
        cmd_push     = 1'b0;
        if (accept) begin
            case (op)
                sps_pkg::OP_LOAD_A: begin
                    if (count_a_reg < CAP) begin
                        a_wr_en      = 1'b1;
                        count_a_next = count_a_reg + 1'b1;
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
                sps_pkg::OP_LOAD_B: begin
                    if (count_b_reg < CAP) begin
                        b_wr_en      = 1'b1;
                        count_b_next = count_b_reg + 1'b1;
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
                sps_pkg::OP_SUB: begin
                    cmd_push     = 1'b1;
                    count_a_next = '0;
                    count_b_next = '0;
                    dropped_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_a_reg <= '0;
            count_b_reg <= '0;
            dropped_reg <= 1'b0;
        end else begin
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

### hdl/sps_cmd_fifo.sv
`timescale 1ns / 1ps

module sps_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sps_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sps_pkg::cmd_t pop_cmd,
    output logic          empty
);
    sps_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign empty   = (fill_reg == 2'd0);
    assign do_push = push && (fill_reg != 2'd2);
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping for a two-entry queue.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### hdl/sps_back.sv
`timescale 1ns / 1ps

module sps_back #(
    parameter int MAX_TERMS = sps_pkg::MAX_TERMS_DEF,
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_avail,
    input  sps_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    output logic                        idle,
    output logic [AW-1:0]               a_rd_addr,
    output logic [AW-1:0]               b_rd_addr,
    input  logic [sps_pkg::TERM_W-1:0]  a_rd_term,
    input  logic [sps_pkg::TERM_W-1:0]  b_rd_term,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sps_pkg::RCOEF_W-1:0] out_coef,
    output logic [sps_pkg::EXP_W-1:0]   out_exp,
    output logic                        out_term_valid,
    output logic                        out_last,
    output logic [sps_pkg::TCNT_W-1:0]  out_count,
    output logic                        out_overflow
);
    localparam int CW  = sps_pkg::COEF_W;
    localparam int EW  = sps_pkg::EXP_W;
    localparam int RW  = sps_pkg::RCOEF_W;
    localparam int NW  = sps_pkg::TCNT_W;
    localparam int KW  = sps_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [KW-1:0]   ca_reg, ca_next, cb_reg, cb_next;
    logic [KW-1:0]   i_reg, i_next, j_reg, j_next;
    logic            drop_reg, drop_next;
    logic [NW-1:0]   n_reg, n_next;
    logic            hold_valid_reg, hold_valid_next;
    logic [RW-1:0]   hold_coef_reg, hold_coef_next;
    logic [EW-1:0]   hold_exp_reg, hold_exp_next;
    logic [NW-1:0]   hold_cnt_reg, hold_cnt_next;

    logic            out_valid_reg, out_valid_next;
    logic [RW-1:0]   out_coef_reg, out_coef_next;
    logic [EW-1:0]   out_exp_reg, out_exp_next;
    logic            out_tv_reg, out_tv_next;
    logic            out_last_reg, out_last_next;
    logic [NW-1:0]   out_cnt_reg, out_cnt_next;
    logic            out_ovf_reg, out_ovf_next;

    logic signed [CW-1:0] a_coef, b_coef;
    logic signed [EW-1:0] a_exp, b_exp;
    logic                 a_more, b_more, take_a, take_b;
    logic signed [RW-1:0] diff;
    logic [EW-1:0]        diff_exp;
    logic                 out_free;

    assign a_coef    = a_rd_term[CW-1:0];
    assign a_exp     = a_rd_term[sps_pkg::TERM_W-1:CW];
    assign b_coef    = b_rd_term[CW-1:0];
    assign b_exp     = b_rd_term[sps_pkg::TERM_W-1:CW];
    assign a_rd_addr = i_reg[AW-1:0];
    assign b_rd_addr = j_reg[AW-1:0];
    assign idle      = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;

    // Pick the head with the lower exponent, or both on a tie.
    always_comb begin
        a_more = (i_reg < ca_reg);
        b_more = (j_reg < cb_reg);
        take_a = !b_more || (a_more && (a_exp < b_exp));
        take_b = !take_a && (!a_more || (a_exp > b_exp));
        if (take_a) begin
            diff = RW'(a_coef);
        end else if (take_b) begin
            diff = -RW'(b_coef);
        end else begin
            diff = RW'(a_coef) - RW'(b_coef);
        end
        diff_exp = take_b ? b_exp : a_exp;
    end

    // Merge sequencer. A nonzero term waits in the hold register until the
    // next one is found, so that the final term can carry the last flag.
    always_comb begin
        state_next      = state_reg;
        ca_next         = ca_reg;
        cb_next         = cb_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        drop_next       = drop_reg;
        n_next          = n_reg;
        hold_valid_next = hold_valid_reg;
        hold_coef_next  = hold_coef_reg;
        hold_exp_next   = hold_exp_reg;
        hold_cnt_next   = hold_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_coef_next   = out_coef_reg;
        out_exp_next    = out_exp_reg;
        out_tv_next     = out_tv_reg;
        out_last_next   = out_last_reg;
        out_cnt_next    = out_cnt_reg;
        out_ovf_next    = out_ovf_reg;
        cmd_pop         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_avail) begin
                    cmd_pop         = 1'b1;
                    ca_next         = cmd.count_a;
                    cb_next         = cmd.count_b;
                    drop_next       = cmd.dropped;
                    i_next          = '0;
                    j_next          = '0;
                    n_next          = '0;
                    hold_valid_next = 1'b0;
                    state_next      = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (a_more || b_more) begin
                    if (!((diff != '0) && hold_valid_reg) || out_free) begin
                        if (!take_b) begin
                            i_next = i_reg + 1'b1;
                        end
                        if (!take_a) begin
                            j_next = j_reg + 1'b1;
                        end
                        if (diff != '0) begin
                            if (hold_valid_reg) begin
                                out_valid_next = 1'b1;
                                out_coef_next  = hold_coef_reg;
                                out_exp_next   = hold_exp_reg;
                                out_tv_next    = 1'b1;
                                out_last_next  = 1'b0;
                                out_cnt_next   = hold_cnt_reg;
                                out_ovf_next   = drop_reg;
                            end
                            hold_valid_next = 1'b1;
                            hold_coef_next  = diff;
                            hold_exp_next   = diff_exp;
                            hold_cnt_next   = n_reg + 1'b1;
                            n_next          = n_reg + 1'b1;
                        end
                        state_next = ST_READ;
                    end
                end else if (out_free) begin
                    // Both lists consumed: release the held term or an empty item.
                    out_valid_next  = 1'b1;
                    out_coef_next   = hold_valid_reg ? hold_coef_reg : '0;
                    out_exp_next    = hold_valid_reg ? hold_exp_reg : '0;
                    out_tv_next     = hold_valid_reg;
                    out_last_next   = 1'b1;
                    out_cnt_next    = hold_valid_reg ? hold_cnt_reg : '0;
                    out_ovf_next    = drop_reg;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ca_reg        <= ca_next;
        cb_reg        <= cb_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        drop_reg      <= drop_next;
        n_reg         <= n_next;
        hold_coef_reg <= hold_coef_next;
        hold_exp_reg  <= hold_exp_next;
        hold_cnt_reg  <= hold_cnt_next;
        out_coef_reg  <= out_coef_next;
        out_exp_reg   <= out_exp_next;
        out_tv_reg    <= out_tv_next;
        out_last_reg  <= out_last_next;
        out_cnt_reg   <= out_cnt_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_coef       = out_coef_reg;
    assign out_exp        = out_exp_reg;
    assign out_term_valid = out_tv_reg;
    assign out_last       = out_last_reg;
    assign out_count      = out_cnt_reg;
    assign out_overflow   = out_ovf_reg;

endmodule

### hdl/sparse_polynomial_subtract_unit.sv
`timescale 1ns / 1ps

// Sparse polynomial subtractor. Load requests store (coefficient, exponent)
// terms into list A or list B, one request per cycle while s_tready is high,
// up to MAX_TERMS per list; further loads are dropped and reported on the
// overflow bit of the next subtract's results. A subtract request merges both
// lists by rising exponent and streams A - B, one nonzero term per result, with
// a running term count and tlast on the final result; an all-zero difference
// yields a single result with tuser low. Each merge step passes through a read
// state, for the registered read of the two term RAMs, then the compare, and
// consumes one term from each list on equal exponents or one term otherwise;
// an output stall holds the compare. While a subtract is running, s_tready
// stays low; both lists and the overflow flag are empty afterwards.
module sparse_polynomial_subtract_unit #(
    parameter int MAX_TERMS = sps_pkg::MAX_TERMS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: coefficient [15:0], exponent [31:16]
    input  logic [sps_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: operation [1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: result_coefficient [16:0], result_exponent [32:17],
    //          term_count [39:33], overflow [40], zero fill [47:41]
    output logic [sps_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tuser: term_valid [0]
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int PAD_W = sps_pkg::M_DATA_W - sps_pkg::RCOEF_W - sps_pkg::EXP_W
                           - sps_pkg::TCNT_W - 1;

    logic                          accept;
    logic                          a_wr_en, b_wr_en;
    logic [AW-1:0]                 a_wr_addr, b_wr_addr, a_rd_addr, b_rd_addr;
    logic [sps_pkg::TERM_W-1:0]    wr_term, a_rd_term, b_rd_term;
    logic                          cmd_push, cmd_pop, cmd_empty, back_idle;
    sps_pkg::cmd_t                 push_cmd, pop_cmd;
    logic [sps_pkg::RCOEF_W-1:0]   out_coef;
    logic [sps_pkg::EXP_W-1:0]     out_exp;
    logic [sps_pkg::TCNT_W-1:0]    out_count;
    logic                          out_term_valid, out_overflow;

    // Loads wait until the merge engine has finished reading the lists.
    assign s_tready = cmd_empty && back_idle;
    assign accept   = s_tvalid && s_tready;

    sps_front #(.MAX_TERMS(MAX_TERMS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .operation   (s_tuser),
        .coefficient (s_tdata[sps_pkg::COEF_W-1:0]),
        .exponent    (s_tdata[sps_pkg::TERM_W-1:sps_pkg::COEF_W]),
        .a_wr_en     (a_wr_en),
        .b_wr_en     (b_wr_en),
        .a_wr_addr   (a_wr_addr),
        .b_wr_addr   (b_wr_addr),
        .wr_term     (wr_term),
        .cmd_push    (cmd_push),
        .cmd         (push_cmd)
    );

    sps_ram #(.WIDTH(sps_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_ram_a (
        .clk     (aclk),
        .wr_en   (a_wr_en),
        .wr_addr (a_wr_addr),
        .wr_data (wr_term),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_term)
    );

    sps_ram #(.WIDTH(sps_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_ram_b (
        .clk     (aclk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (wr_term),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_term)
    );

    sps_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .pop_cmd  (pop_cmd),
        .empty    (cmd_empty)
    );

    sps_back #(.MAX_TERMS(MAX_TERMS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_avail      (!cmd_empty),
        .cmd            (pop_cmd),
        .cmd_pop        (cmd_pop),
        .idle           (back_idle),
        .a_rd_addr      (a_rd_addr),
        .b_rd_addr      (b_rd_addr),
        .a_rd_term      (a_rd_term),
        .b_rd_term      (b_rd_term),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_coef       (out_coef),
        .out_exp        (out_exp),
        .out_term_valid (out_term_valid),
        .out_last       (m_tlast),
        .out_count      (out_count),
        .out_overflow   (out_overflow)
    );

    // Result packing.
    assign m_tdata    = {{PAD_W{1'b0}}, out_overflow, out_count, out_exp, out_coef};
    assign m_tuser[0] = out_term_valid;

endmodule
